/* hdl/tcw_pkg.sv */
// shared types, codes and constants of the text console writer
package tcw_pkg;

    localparam int COLUMNS_DEF = 80;
    localparam int ROWS_DEF    = 25;

    localparam int OP_W    = 2;
    localparam int CHAR_W  = 8;
    localparam int INDEX_W = 11;
    localparam int CELL_W  = 16;
    localparam int ROW_W   = 5;
    localparam int COL_W   = 7;
    localparam int COLOR_W = 8;

    localparam logic [CHAR_W-1:0]  BLANK_CHAR   = 8'h20;
    localparam logic [CHAR_W-1:0]  NEWLINE_CHAR = 8'h0A;
    localparam logic [COLOR_W-1:0] RESET_COLOR  = 8'h0F;

    typedef enum logic [OP_W-1:0] {
        OP_PUT   = 2'd0,
        OP_READ  = 2'd1,
        OP_CLEAR = 2'd2,
        OP_NOP   = 2'd3
    } op_t;

    typedef enum logic [2:0] {
        ST_INIT,
        ST_IDLE,
        ST_EXEC,
        ST_RD_WAIT,
        ST_COPY,
        ST_COPY_LAST,
        ST_FILL,
        ST_RESULT
    } seq_state_t;

    typedef struct packed {
        logic [CELL_W-1:0] cell_value;
        logic [ROW_W-1:0]  cursor_row_out;
        logic [COL_W-1:0]  cursor_col_out;
        logic              did_scroll;
    } result_t;

endpackage

/* hdl/tcw_if.sv */
// request and result channel interfaces of the text console writer
interface tcw_cmd_if;
    import tcw_pkg::*;

    logic               valid;
    logic               ready;
    logic [OP_W-1:0]    op;
    logic [CHAR_W-1:0]  char_code;
    logic [INDEX_W-1:0] cell_index;

    modport source (output valid, output op, output char_code, output cell_index,
                    input ready);
    modport sink   (input valid, input op, input char_code, input cell_index,
                    output ready);
endinterface

interface tcw_rsp_if;
    import tcw_pkg::*;

    logic              valid;
    logic              ready;
    logic [CELL_W-1:0] cell_value;
    logic [ROW_W-1:0]  cursor_row_out;
    logic [COL_W-1:0]  cursor_col_out;
    logic              did_scroll;

    modport source (output valid, output cell_value, output cursor_row_out,
                    output cursor_col_out, output did_scroll, input ready);
    modport sink   (input valid, input cell_value, input cursor_row_out,
                    input cursor_col_out, input did_scroll, output ready);
endinterface

/* hdl/tcw_screen_mem.sv */
// screen store: one write port, one read port with registered read data
module tcw_screen_mem #(
    parameter int   DEPTH  = 2000,
    parameter int   DATA_W = 16,
    localparam int  AW     = $clog2(DEPTH)
) (
    input  logic              clk,
    input  logic              we,
    input  logic [AW-1:0]     waddr,
    input  logic [DATA_W-1:0] wdata,
    input  logic              re,
    input  logic [AW-1:0]     raddr,
    output logic [DATA_W-1:0] rdata
);

    logic [DATA_W-1:0] cells_mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            cells_mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata <= cells_mem[raddr];
        end
    end

endmodule

/* hdl/tcw_seq.sv */
// sequencer: cursor, sweep counter and screen store access
module tcw_seq
    import tcw_pkg::COLOR_W, tcw_pkg::CELL_W, tcw_pkg::result_t;
#(
    parameter int  COLUMNS = tcw_pkg::COLUMNS_DEF,
    parameter int  ROWS    = tcw_pkg::ROWS_DEF,
    localparam int CELLS   = ROWS * COLUMNS,
    localparam int AW      = $clog2(CELLS)
) (
    input  logic               clk,
    input  logic               rst_n,
    tcw_cmd_if.sink            cmd,
    input  logic [COLOR_W-1:0] text_color,
    input  logic               out_free,
    output logic               res_valid,
    output result_t            res,
    output logic               mem_we,
    output logic [AW-1:0]      mem_waddr,
    output logic [CELL_W-1:0]  mem_wdata,
    output logic               mem_re,
    output logic [AW-1:0]      mem_raddr,
    input  logic [CELL_W-1:0]  mem_rdata
);
    import tcw_pkg::*;

    localparam int RW = $clog2(ROWS);
    localparam int CW = $clog2(COLUMNS);
    localparam logic [AW-1:0] LAST_ROW_BASE = AW'((ROWS - 1) * COLUMNS);
    localparam logic [AW-1:0] LAST_CELL     = AW'(CELLS - 1);
    localparam logic [AW-1:0] COLS_A        = AW'(COLUMNS);
    localparam logic [RW-1:0] LAST_ROW      = RW'(ROWS - 1);
    localparam logic [CW-1:0] LAST_COL      = CW'(COLUMNS - 1);

    seq_state_t         state_reg, state_next;
    op_t                op_reg, op_next;
    logic [CHAR_W-1:0]  ch_reg, ch_next;
    logic [INDEX_W-1:0] idx_reg, idx_next;
    logic [AW-1:0]      cnt_reg, cnt_next;
    logic [AW-1:0]      pos_reg, pos_next;
    logic [RW-1:0]      row_reg, row_next;
    logic [CW-1:0]      col_reg, col_next;
    logic               scroll_reg, scroll_next;
    logic [CELL_W-1:0]  value_reg, value_next;
    logic               pipe_valid_reg, pipe_valid_next;
    logic [AW-1:0]      pipe_addr_reg, pipe_addr_next;

    logic read_in_range;
    logic at_eol;
    logic at_bottom;

    assign read_in_range = 16'(idx_reg) < 16'(CELLS);
    assign at_eol        = (ch_reg == NEWLINE_CHAR) || (col_reg == LAST_COL);
    assign at_bottom     = row_reg == LAST_ROW;

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_INIT:
            begin
                if (cnt_reg == LAST_CELL)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (cmd.valid)
                begin
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                case (op_reg)
                    OP_PUT:
                    begin
                        if (at_eol && at_bottom)
                        begin
                            state_next = ST_COPY;
                        end
                        else
                        begin
                            state_next = ST_RESULT;
                        end
                    end
                    OP_READ:
                    begin
                        state_next = read_in_range ? ST_RD_WAIT : ST_RESULT;
                    end
                    OP_CLEAR: state_next = ST_FILL;
                    default:  state_next = ST_RESULT;
                endcase
            end
            ST_RD_WAIT: state_next = ST_RESULT;
            ST_COPY:
            begin
                if (cnt_reg == LAST_ROW_BASE - AW'(1))
                begin
                    state_next = ST_COPY_LAST;
                end
            end
            ST_COPY_LAST: state_next = ST_FILL;
            ST_FILL:
            begin
                if (cnt_reg == LAST_CELL)
                begin
                    state_next = ST_RESULT;
                end
            end
            ST_RESULT:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_INIT;
        endcase
    end

    // outputs and store access
    always_comb
    begin
        cmd.ready = 1'b0;
        res_valid = 1'b0;
        mem_we    = 1'b0;
        mem_waddr = cnt_reg;
        mem_wdata = {text_color, BLANK_CHAR};
        mem_re    = 1'b0;
        mem_raddr = cnt_reg + COLS_A;
        case (state_reg)
            ST_INIT:
            begin
                mem_we    = 1'b1;
                mem_wdata = {RESET_COLOR, BLANK_CHAR};
            end
            ST_IDLE: cmd.ready = 1'b1;
            ST_EXEC:
            begin
                if (op_reg == OP_PUT && ch_reg != NEWLINE_CHAR)
                begin
                    mem_we    = 1'b1;
                    mem_waddr = pos_reg;
                    mem_wdata = {text_color, ch_reg};
                end
                if (op_reg == OP_READ && read_in_range)
                begin
                    mem_re    = 1'b1;
                    mem_raddr = AW'(idx_reg);
                end
            end
            ST_COPY:
            begin
                mem_re    = 1'b1;
                mem_we    = pipe_valid_reg;
                mem_waddr = pipe_addr_reg;
                mem_wdata = mem_rdata;
            end
            ST_COPY_LAST:
            begin
                mem_we    = pipe_valid_reg;
                mem_waddr = pipe_addr_reg;
                mem_wdata = mem_rdata;
            end
            ST_FILL:   mem_we = 1'b1;
            ST_RESULT: res_valid = 1'b1;
            default:   mem_we = 1'b0;
        endcase
    end

    // datapath: cursor, counter and result
    always_comb
    begin
        op_next         = op_reg;
        ch_next         = ch_reg;
        idx_next        = idx_reg;
        cnt_next        = cnt_reg;
        pos_next        = pos_reg;
        row_next        = row_reg;
        col_next        = col_reg;
        scroll_next     = scroll_reg;
        value_next      = value_reg;
        pipe_valid_next = 1'b0;
        pipe_addr_next  = cnt_reg;
        case (state_reg)
            ST_INIT: cnt_next = cnt_reg + AW'(1);
            ST_IDLE:
            begin
                op_next     = op_t'(cmd.op);
                ch_next     = cmd.char_code;
                idx_next    = cmd.cell_index;
                scroll_next = 1'b0;
                value_next  = '0;
            end
            ST_EXEC:
            begin
                case (op_reg)
                    OP_PUT:
                    begin
                        if (at_eol)
                        begin
                            col_next = '0;
                            if (at_bottom)
                            begin
                                pos_next    = LAST_ROW_BASE;
                                scroll_next = 1'b1;
                                cnt_next    = '0;
                            end
                            else
                            begin
                                row_next = row_reg + RW'(1);
                                pos_next = pos_reg - AW'(col_reg) + COLS_A;
                            end
                        end
                        else
                        begin
                            col_next = col_reg + CW'(1);
                            pos_next = pos_reg + AW'(1);
                        end
                    end
                    OP_CLEAR:
                    begin
                        row_next = '0;
                        col_next = '0;
                        pos_next = '0;
                        cnt_next = '0;
                    end
                    default: cnt_next = cnt_reg;
                endcase
            end
            ST_RD_WAIT: value_next = mem_rdata;
            ST_COPY:
            begin
                // read one row down, write it back in the next cycle
                pipe_valid_next = 1'b1;
                pipe_addr_next  = cnt_reg;
                cnt_next        = cnt_reg + AW'(1);
            end
            ST_COPY_LAST: cnt_next = LAST_ROW_BASE;
            ST_FILL:      cnt_next = cnt_reg + AW'(1);
            default:      cnt_next = cnt_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_INIT;
            cnt_reg        <= '0;
            pos_reg        <= '0;
            row_reg        <= '0;
            col_reg        <= '0;
            pipe_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            cnt_reg        <= cnt_next;
            pos_reg        <= pos_next;
            row_reg        <= row_next;
            col_reg        <= col_next;
            pipe_valid_reg <= pipe_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg        <= op_next;
        ch_reg        <= ch_next;
        idx_reg       <= idx_next;
        scroll_reg    <= scroll_next;
        value_reg     <= value_next;
        pipe_addr_reg <= pipe_addr_next;
    end

    assign res.cell_value     = value_reg;
    assign res.cursor_row_out = ROW_W'(row_reg);
    assign res.cursor_col_out = COL_W'(col_reg);
    assign res.did_scroll     = scroll_reg;

endmodule

/* hdl/text_console_writer.sv */
// text console writer top level: colour register, sequencer, screen store, result register
//
// A text console holding ROWS x COLUMNS 16-bit cells (attribute byte high, character
// byte low). Each request on cmd is one operation: put a character at the cursor
// (newline moves to the start of the next row, the last column wraps, moving past
// the bottom row scrolls the screen up one row and blanks the bottom row), read one
// cell, or clear the screen and home the cursor. Every request gives exactly one
// result on rsp with the cell read (zero for other operations), the cursor after the
// operation and a scroll flag. All store traffic goes through one single-port-write
// memory under a small sequencer, so one request is in flight at a time and cmd.ready
// is low while it is worked on; the next request is taken while a result still waits
// in the output register. A read of an index past the last cell does not read the
// store. A clear sweeps every cell one per cycle. A scroll copies rows 1 to ROWS-1
// one cell per cycle through the registered read port, then blanks the bottom row.
// After reset the store is blanked in the reset colour by a like sweep before the
// first request is taken; colour writes are taken throughout. cfg_we/cfg_wdata load
// the text colour (reset 0x0F) and must only be used while no request is outstanding.
module text_console_writer
    import tcw_pkg::COLOR_W, tcw_pkg::CELL_W;
#(
    parameter int COLUMNS = tcw_pkg::COLUMNS_DEF,
    parameter int ROWS    = tcw_pkg::ROWS_DEF
) (
    input  logic               clk,
    input  logic               rst_n,
    tcw_cmd_if.sink            cmd,
    tcw_rsp_if.source          rsp,
    input  logic               cfg_we,
    input  logic [COLOR_W-1:0] cfg_wdata
);
    import tcw_pkg::*;

    localparam int CELLS = ROWS * COLUMNS;
    localparam int AW    = $clog2(CELLS);

    // current text colour, used by puts, clears and the scroll blank row
    logic [COLOR_W-1:0] text_color_reg;

    // sequencer to result register
    logic    res_valid;
    result_t res;
    logic    out_free;

    // result register
    logic    out_valid_reg, out_valid_next;
    result_t out_data_reg, out_data_next;

    // screen store port
    logic              mem_we;
    logic [AW-1:0]     mem_waddr;
    logic [CELL_W-1:0] mem_wdata;
    logic              mem_re;
    logic [AW-1:0]     mem_raddr;
    logic [CELL_W-1:0] mem_rdata;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            text_color_reg <= RESET_COLOR;
        end
        else if (cfg_we)
        begin
            text_color_reg <= cfg_wdata;
        end
    end

    tcw_seq #(
        .COLUMNS (COLUMNS),
        .ROWS    (ROWS)
    ) u_seq (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .text_color (text_color_reg),
        .out_free   (out_free),
        .res_valid  (res_valid),
        .res        (res),
        .mem_we     (mem_we),
        .mem_waddr  (mem_waddr),
        .mem_wdata  (mem_wdata),
        .mem_re     (mem_re),
        .mem_raddr  (mem_raddr),
        .mem_rdata  (mem_rdata)
    );

    tcw_screen_mem #(
        .DEPTH  (CELLS),
        .DATA_W (CELL_W)
    ) u_mem (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .re    (mem_re),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    // output register frees up when empty or taken this cycle
    assign out_free = !out_valid_reg || rsp.ready;

    always_comb
    begin
        out_valid_next = out_valid_reg;
        out_data_next  = out_data_reg;
        if (out_free)
        begin
            out_valid_next = res_valid;
            if (res_valid)
            begin
                out_data_next = res;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_data_reg <= out_data_next;
    end

    assign rsp.valid          = out_valid_reg;
    assign rsp.cell_value     = out_data_reg.cell_value;
    assign rsp.cursor_row_out = out_data_reg.cursor_row_out;
    assign rsp.cursor_col_out = out_data_reg.cursor_col_out;
    assign rsp.did_scroll     = out_data_reg.did_scroll;

endmodule

/* hdl/tcw_checker.sv */
// port-level checks of the text console writer and their binding
module tcw_checker
    import tcw_pkg::CELL_W, tcw_pkg::ROW_W, tcw_pkg::COL_W;
#(
    parameter int COLUMNS = tcw_pkg::COLUMNS_DEF,
    parameter int ROWS    = tcw_pkg::ROWS_DEF
) (
    input logic              clk,
    input logic              rst_n,
    input logic              cmd_valid,
    input logic              cmd_ready,
    input logic              rsp_valid,
    input logic              rsp_ready,
    input logic [CELL_W-1:0] cell_value,
    input logic [ROW_W-1:0]  cursor_row_out,
    input logic [COL_W-1:0]  cursor_col_out,
    input logic              did_scroll
);

    // busy once a request is taken
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd_valid && cmd_ready |=> !cmd_ready)
        else $error("request taken while previous one still in work");

    // a scroll leaves the cursor at the start of the bottom row
    assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && did_scroll |->
            cursor_col_out == '0 && cursor_row_out == ROW_W'(ROWS - 1))
        else $error("scroll reported with cursor away from bottom row start");

    // cursor stays on the screen
    assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> 32'(cursor_col_out) < COLUMNS && 32'(cursor_row_out) < ROWS)
        else $error("cursor reported off screen");

    // a stalled result holds
    assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid && $stable(cell_value)
            && $stable(cursor_row_out) && $stable(cursor_col_out) && $stable(did_scroll))
        else $error("stalled result changed");

endmodule

bind text_console_writer tcw_checker #(
    .COLUMNS (COLUMNS),
    .ROWS    (ROWS)
) u_tcw_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .cmd_valid      (cmd.valid),
    .cmd_ready      (cmd.ready),
    .rsp_valid      (rsp.valid),
    .rsp_ready      (rsp.ready),
    .cell_value     (rsp.cell_value),
    .cursor_row_out (rsp.cursor_row_out),
    .cursor_col_out (rsp.cursor_col_out),
    .did_scroll     (rsp.did_scroll)
);
